/* sv/sstfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sstfr_pkg
// Types and byte codes shared by the frame receiver and its channel interfaces.
// ----------------------------------------------------------------------------
package sstfr_pkg;

    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned CFG_W    = 64;

    typedef logic [7:0]          rx_byte_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    localparam rx_byte_t SOH_CODE = 8'h01;
    localparam rx_byte_t STX_CODE = 8'h02;
    localparam rx_byte_t EOT_CODE = 8'h04;

endpackage
`default_nettype wire

/* sv/sstfr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sstfr_if
// Valid/ready channels: received bytes, delivered payload beats, config writes.
// ----------------------------------------------------------------------------
interface sstfr_rx_if;
    import sstfr_pkg::*;

    logic     valid;
    logic     ready;
    rx_byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sstfr_frame_if;
    import sstfr_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t frame_opcode;
    logic [7:0] payload_byte;
    pos_t    byte_position;
    logic    last_byte;

    modport source (output valid, output frame_opcode, output payload_byte,
                    output byte_position, output last_byte, input ready);
    modport sink   (input valid, input frame_opcode, input payload_byte,
                    input byte_position, input last_byte, output ready);
endinterface

interface sstfr_cfg_if;
    import sstfr_pkg::*;

    logic valid;
    logic ready;
    cfg_t opcode_lengths;

    modport source (output valid, output opcode_lengths, input ready);
    modport sink   (input valid, input opcode_lengths, output ready);
endinterface
`default_nettype wire

/* sv/soh_stx_eot_frame_receiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// soh_stx_eot_frame_receiver
// Readout: a good EOT starts the sequencer; each beat goes through the registered
// memory read and the output register, one beat per cycle while the sink takes them.
// Throughput: one received byte per cycle; after a good EOT the rx side holds
// off until the last payload byte has been read from the buffer memory, which
// takes longer while the sink stalls.
// Reset: clears phase, counters and output valid; buffer memory is not cleared.
// ----------------------------------------------------------------------------
module soh_stx_eot_frame_receiver #(
    parameter int unsigned NUM_OPCODES  = 8,
    parameter int unsigned BUFFER_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sstfr_rx_if.sink         rx,
    sstfr_frame_if.source    frame,
    sstfr_cfg_if.sink        cfg
);
    import sstfr_pkg::*;

    localparam int unsigned CW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [CW-1:0] LEN_MAX = CW'(BUFFER_BYTES - 1);

    // Frame phase codes
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_STX    = 3'd1;
    localparam logic [2:0] PH_OPCODE = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_EOT    = 3'd4;

    // Config register: byte k is the payload length of opcode k
    cfg_t          lengths_reg;

    // Receive side
    logic [2:0]    phase_reg,  phase_next;
    logic [CW-1:0] count_reg,  count_next;
    opcode_t       opcode_reg, opcode_next;

    // Readout sequencer
    logic          dlv_active_reg, dlv_active_next;
    logic [CW-1:0] dlv_idx_reg,    dlv_idx_next;
    logic [CW-1:0] dlv_len_reg;
    opcode_t       dlv_op_reg;
    logic          dlv_start;

    // Read pipeline: one beat in flight from the memory
    logic          rd_pending_reg, rd_pending_next;
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] rd_pos_reg;
    opcode_t       rd_op_reg;
    logic          rd_last_reg;

    // Output register
    logic          out_valid_reg, out_valid_next;
    opcode_t       out_op_reg;
    logic [7:0]    out_data_reg;
    logic [CW-1:0] out_pos_reg;
    logic          out_last_reg;

    // Payload buffer
    logic [7:0]    store [BUFFER_BYTES];
    logic          mem_we;

    logic          rx_fire;
    logic          out_free;
    logic          rd_issue;
    logic          rd_load;
    logic [7:0]    len_raw;
    logic [CW-1:0] cur_len;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !dlv_active_reg;
    assign rx_fire   = rx.valid && rx.ready;

    // Look up and clamp the payload length of the current opcode
    assign len_raw = lengths_reg[opcode_reg*8 +: 8];
    assign cur_len = (len_raw > 8'(BUFFER_BYTES - 1)) ? LEN_MAX : len_raw[CW-1:0];

    // Frame parser
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        opcode_next = opcode_reg;
        mem_we      = 1'b0;
        dlv_start   = 1'b0;
        if (rx_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx.rx_byte == SOH_CODE)
                    begin
                        phase_next = PH_STX;
                    end
                end
                PH_STX:
                begin
                    phase_next = (rx.rx_byte == STX_CODE) ? PH_OPCODE : PH_HUNT;
                end
                PH_OPCODE:
                begin
                    if (rx.rx_byte < 8'(NUM_OPCODES))
                    begin
                        opcode_next = rx.rx_byte[OPCODE_W-1:0];
                        phase_next  = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if ({1'b0, count_reg} < (CW+1)'(BUFFER_BYTES - 1))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        // Length may have shrunk below the stored count: end here too
                        if (count_next >= cur_len)
                        begin
                            phase_next = PH_EOT;
                            count_next = '0;
                        end
                    end
                end
                PH_EOT:
                begin
                    // Unregistered opcode (zero length) is dropped like a bad EOT
                    dlv_start   = (rx.rx_byte == EOT_CODE) && (cur_len != '0);
                    phase_next  = PH_HUNT;
                    opcode_next = '0;
                end
                default:
                begin
                    phase_next  = PH_HUNT;
                    opcode_next = '0;
                    count_next  = '0;
                end
            endcase
        end
    end

    // Readout: issue a memory read whenever the beat in flight can move on
    assign out_free = !out_valid_reg || frame.ready;
    assign rd_load  = rd_pending_reg && out_free;
    assign rd_issue = dlv_active_reg && (!rd_pending_reg || out_free);

    always_comb
    begin
        dlv_active_next = dlv_active_reg;
        dlv_idx_next    = dlv_idx_reg;
        if (dlv_start)
        begin
            dlv_active_next = 1'b1;
            dlv_idx_next    = '0;
        end
        else if (rd_issue)
        begin
            dlv_idx_next = dlv_idx_reg + CW'(1);
            if (dlv_idx_reg + CW'(1) == dlv_len_reg)
            begin
                dlv_active_next = 1'b0;
            end
        end

        if (rd_issue)
        begin
            rd_pending_next = 1'b1;
        end
        else if (rd_load)
        begin
            rd_pending_next = 1'b0;
        end
        else
        begin
            rd_pending_next = rd_pending_reg;
        end

        if (rd_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lengths_reg    <= '0;
            phase_reg      <= PH_HUNT;
            count_reg      <= '0;
            opcode_reg     <= '0;
            dlv_active_reg <= 1'b0;
            dlv_idx_reg    <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                lengths_reg <= cfg.opcode_lengths;
            end
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            opcode_reg     <= opcode_next;
            dlv_active_reg <= dlv_active_next;
            dlv_idx_reg    <= dlv_idx_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: latch frame tag at EOT, tag each beat at read issue
    always_ff @(posedge clk)
    begin
        if (dlv_start)
        begin
            dlv_len_reg <= cur_len;
            dlv_op_reg  <= opcode_reg;
        end
        if (rd_issue)
        begin
            rd_pos_reg  <= dlv_idx_reg;
            rd_op_reg   <= dlv_op_reg;
            rd_last_reg <= (dlv_idx_reg + CW'(1) == dlv_len_reg);
        end
        if (rd_load)
        begin
            out_op_reg   <= rd_op_reg;
            out_data_reg <= rd_data_reg;
            out_pos_reg  <= rd_pos_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    // Buffer memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[count_reg] <= rx.rx_byte;
        end
        if (rd_issue)
        begin
            rd_data_reg <= store[dlv_idx_reg];
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_opcode  = out_op_reg;
    assign frame.payload_byte  = out_data_reg;
    assign frame.byte_position = POS_W'(out_pos_reg);
    assign frame.last_byte     = out_last_reg;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SOH/STX/EOT frame receiver. A scoreboard
// tracks the receiver phase, the payload buffer and the length table. It
// predicts the payload beats of every good frame and compares each delivered
// beat field by field. Stimulus is a short directed run through the framing
// corner cases, then random valid frames mixed with broken ones. The length
// table is rewritten between runs, sometimes in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sstfr_pkg::*;

    localparam int unsigned N_OPCODES       = 8;
    localparam int unsigned BUF_BYTES       = 64;
    localparam int unsigned MAX_LEN         = BUF_BYTES - 1;
    localparam int unsigned CLK_PERIOD      = 10;
    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned TARGET_BYTES    = 460;
    localparam int unsigned RUN_BYTES       = 50;   // bytes per length-table setting
    localparam int unsigned SETTLE_CYCLES   = 8;    // idle wait before each length-table write
    localparam int unsigned TAIL_CYCLES     = 20;
    localparam int unsigned WATCHDOG_CYCLES = 2000;

    // Directed length table: op0=1, op1=2, op2 unregistered, op3=3, op4=5,
    // op5=8, op6=64 (clamps to 63), op7=2. The second copy shrinks op3 to 1.
    localparam cfg_t DIRECTED_LENGTHS = 64'h02_40_08_05_03_00_02_01;
    localparam cfg_t SHRUNK_LENGTHS   = 64'h02_40_08_05_01_00_02_01;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_STX,
        PH_OPCODE,
        PH_DATA,
        PH_EOT
    } rx_phase_e;

    typedef struct {
        opcode_t    opcode;
        logic [7:0] data;
        pos_t       pos;
        logic       last;
    } payload_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the receiver and holds the payload beats still due.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        cfg_t               lengths;
        rx_phase_e          phase;
        logic [5:0]         count;
        opcode_t            op;
        rx_byte_t           store [BUF_BYTES];
        logic [BUF_BYTES-1:0] written;
        payload_beat_t      due_beats [$];
        int unsigned        errors;
        int unsigned        frames;
        int unsigned        beats;

        function new();
            lengths = '0;
            phase   = PH_HUNT;
            count   = '0;
            op      = '0;
            written = '0;
            errors  = 0;
            frames  = 0;
            beats   = 0;
            foreach (store[i])
                store[i] = '0;
        endfunction

        function int unsigned clamp_len(cfg_t table_val, opcode_t o);
            int unsigned len;
            len = 32'(table_val[int'(o) * 8 +: 8]);
            if (len > MAX_LEN)
                len = MAX_LEN;
            return len;
        endfunction

        // True when the first n buffer entries have all been written once.
        function bit covers(int unsigned n);
            for (int unsigned i = 0; i < n; i++)
                if (!written[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_cfg(cfg_t v);
            lengths = v;
        endfunction

        function void note_byte(rx_byte_t b);
            int unsigned   len;
            payload_beat_t beat;
            case (phase)
                PH_HUNT:
                begin
                    if (b == SOH_CODE)
                        phase = PH_STX;
                end
                PH_STX:
                begin
                    phase = (b == STX_CODE) ? PH_OPCODE : PH_HUNT;
                end
                PH_OPCODE:
                begin
                    if (b < N_OPCODES)
                    begin
                        op    = b[2:0];
                        phase = PH_DATA;
                    end
                    else
                        phase = PH_HUNT;
                end
                PH_DATA:
                begin
                    // length is re-read on every payload byte
                    if (count < MAX_LEN)
                    begin
                        store[count]   = b;
                        written[count] = 1'b1;
                        count          = count + 6'd1;
                        if (count >= clamp_len(lengths, op))
                        begin
                            phase = PH_EOT;
                            count = '0;
                        end
                    end
                end
                PH_EOT:
                begin
                    len = clamp_len(lengths, op);
                    if (b == EOT_CODE && len != 0)
                    begin
                        for (int unsigned i = 0; i < len; i++)
                        begin
                            beat.opcode = op;
                            beat.data   = store[i];
                            beat.pos    = pos_t'(i);
                            beat.last   = (i + 1 == len);
                            due_beats.push_back(beat);
                        end
                        frames++;
                    end
                    phase = PH_HUNT;
                    op    = '0;
                end
                default:
                begin
                    phase = PH_HUNT;
                    op    = '0;
                    count = '0;
                end
            endcase
        endfunction

        function void check_beat(opcode_t o, logic [7:0] d, pos_t p, logic l);
            payload_beat_t want;
            if (due_beats.size() == 0)
            begin
                $error("unexpected payload beat: opcode %0d position %0d byte 0x%02h",
                       o, p, d);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            beats++;
            if (o !== want.opcode)
            begin
                $error("frame_opcode: expected %0d, got %0d", want.opcode, o);
                errors++;
            end
            if (d !== want.data)
            begin
                $error("payload_byte: expected 0x%02h, got 0x%02h", want.data, d);
                errors++;
            end
            if (p !== want.pos)
            begin
                $error("byte_position: expected %0d, got %0d", want.pos, p);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("last_byte: expected %0d, got %0d", want.last, l);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sstfr_rx_if    rx_if ();
    sstfr_frame_if frame_if ();
    sstfr_cfg_if   cfg_if ();

    soh_stx_eot_frame_receiver #(
        .NUM_OPCODES  (N_OPCODES),
        .BUFFER_BYTES (BUF_BYTES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if.sink),
        .frame (frame_if.source),
        .cfg   (cfg_if.sink)
    );

    frame_scoreboard sb = new();

    // Pacing knobs, in percent of cycles: sender gaps and sink stalls.
    int unsigned send_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned bytes_sent;
    int unsigned cfg_writes;
    int unsigned quiet_cycles;

    // Sink side: drop ready at random according to the current stall rate.
    always @(posedge clk)
        frame_if.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Check every payload beat that the sink accepts. Values sampled here are
    // the ones that stood before the edge, so no race with the drivers.
    always @(posedge clk)
    begin
        if (rst_n && frame_if.valid && frame_if.ready)
            sb.check_beat(frame_if.frame_opcode, frame_if.payload_byte,
                          frame_if.byte_position, frame_if.last_byte);
    end

    // Watchdog: count cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        $display("watchdog: no beat accepted for %0d cycles, %0d payload beats still due",
                 WATCHDOG_CYCLES, sb.due_beats.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one received byte; idle first at the current gap rate, then hold
    // the beat until the receiver takes it.
    task automatic send_byte(input rx_byte_t b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_bytes(input rx_byte_t seq [$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Rewrite the length table once the receiver has nothing left to deliver.
    task automatic write_lengths(input cfg_t v);
        rx_if.valid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_if.valid          <= 1'b1;
        cfg_if.opcode_lengths <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.note_cfg(v);
        cfg_if.valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic rx_byte_t other_than(rx_byte_t code);
        rx_byte_t v;
        v = rx_byte_t'($urandom_range(255));
        if (v == code)
            v = v ^ 8'h80;
        return v;
    endfunction

    // Mostly short payloads; now and then a long one or one that clamps.
    function automatic cfg_t random_lengths();
        cfg_t        v;
        int unsigned pick;
        for (int k = 0; k < N_OPCODES; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                v[k*8 +: 8] = 8'd0;
            else if (pick < 75)
                v[k*8 +: 8] = 8'($urandom_range(1, 6));
            else if (pick < 92)
                v[k*8 +: 8] = 8'($urandom_range(7, 20));
            else
                v[k*8 +: 8] = 8'($urandom_range(21, 255));
        end
        return v;
    endfunction

    // Whole frame from the hunting phase; an unregistered opcode still eats
    // one payload byte.
    task automatic send_frame(input opcode_t op, input bit good_eot);
        int unsigned n;
        n = sb.clamp_len(sb.lengths, op);
        if (n == 0)
            n = 1;
        send_byte(SOH_CODE);
        send_byte(STX_CODE);
        send_byte(rx_byte_t'(op));
        repeat (n)
            send_byte(rx_byte_t'($urandom_range(255)));
        send_byte(good_eot ? EOT_CODE : other_than(EOT_CODE));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t        lengths_val;
        opcode_t     op;
        int unsigned n;
        int unsigned pick;
        int unsigned run_start;
        int unsigned run_no;

        rst_n                 = 1'b0;
        rx_if.valid           = 1'b0;
        rx_if.rx_byte         = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.opcode_lengths = '0;
        frame_if.ready        = 1'b0;
        send_gap_pct          = 29;
        sink_stall_pct        = 53;
        bytes_sent            = 0;
        cfg_writes            = 0;
        quiet_cycles          = 0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed corner cases ---
        // Empty table: every opcode unregistered, so this frame delivers nothing.
        write_lengths('0);
        send_bytes('{SOH_CODE, STX_CODE, 8'h03, 8'hAA, EOT_CODE});

        write_lengths(DIRECTED_LENGTHS);
        // Lowest opcode with an all-ones payload byte.
        send_bytes('{SOH_CODE, STX_CODE, 8'h00, 8'hFF, EOT_CODE});
        // Wrong STX: drop back to hunting.
        send_bytes('{SOH_CODE, 8'h03});
        // Opcode far out of range.
        send_bytes('{SOH_CODE, STX_CODE, 8'hFF});
        // Bad EOT: drop the buffered payload.
        send_bytes('{SOH_CODE, STX_CODE, 8'h01, 8'h55, 8'h80, 8'h05});
        // Shrink op3 mid payload: the next byte ends the payload early.
        send_bytes('{SOH_CODE, STX_CODE, 8'h03, 8'h11});
        write_lengths(SHRUNK_LENGTHS);
        send_bytes('{8'h22, EOT_CODE});

        // --- Random frames, one length table per run ---
        run_no = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            // Second run uses the all-ones table: every length clamps to 63.
            lengths_val = (run_no == 1) ? '1 : random_lengths();
            // A grown length at EOT must not read buffer entries never written.
            if (sb.phase == PH_EOT && !sb.covers(sb.clamp_len(lengths_val, sb.op)))
                lengths_val[int'(sb.op) * 8 +: 8] = 8'd0;
            write_lengths(lengths_val);

            // Finish any frame left open across the table change.
            while (sb.phase != PH_HUNT)
            begin
                if (sb.phase == PH_EOT && $urandom_range(3) != 0)
                    send_byte(EOT_CODE);
                else
                    send_byte(rx_byte_t'($urandom_range(255)));
            end

            run_start = bytes_sent;
            while (bytes_sent - run_start < RUN_BYTES && bytes_sent < TARGET_BYTES)
            begin
                // Pacing by progress: sink-heavy stalls, then sender-heavy gaps, then none.
                if (bytes_sent < TARGET_BYTES / 3)
                begin
                    send_gap_pct   = 29;
                    sink_stall_pct = 53;
                end
                else if (bytes_sent < 2 * TARGET_BYTES / 3)
                begin
                    send_gap_pct   = 53;
                    sink_stall_pct = 29;
                end
                else
                begin
                    send_gap_pct   = 0;
                    sink_stall_pct = 0;
                end

                op   = opcode_t'($urandom_range(N_OPCODES - 1));
                pick = $urandom_range(99);
                if (pick < 75)
                    send_frame(op, 1'b1);
                else if (pick < 82)
                    send_frame(op, 1'b0);
                else if (pick < 88)
                    send_bytes('{SOH_CODE, other_than(STX_CODE)});
                else if (pick < 94)
                    send_bytes('{SOH_CODE, STX_CODE,
                                 rx_byte_t'($urandom_range(N_OPCODES, 255))});
                else
                    send_byte(other_than(SOH_CODE));
            end

            // Half the time, leave a frame open so the next table lands mid frame.
            if (bytes_sent < TARGET_BYTES && $urandom_range(1) == 0)
            begin
                op = opcode_t'($urandom_range(N_OPCODES - 1));
                n  = sb.clamp_len(sb.lengths, op);
                if (n == 0)
                    n = 1;
                send_bytes('{SOH_CODE, STX_CODE, rx_byte_t'(op)});
                repeat ($urandom_range(n))
                    send_byte(rx_byte_t'($urandom_range(255)));
            end
            run_no++;
        end

        // Drain, then give the block time to show any stray beat.
        rx_if.valid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Sent %0d bytes under %0d length tables; %0d frames delivered.",
                 bytes_sent, cfg_writes, sb.frames);
        $display("Compared %0d payload beats, %0d mismatches.", sb.beats, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
